// File: rtl/counter_rate_moving_average_defines.svh
// Assertion helpers used by the top-level RTL file
`ifndef COUNTER_RATE_MOVING_AVERAGE_DEFINES_SVH
`define COUNTER_RATE_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while in reset
`define CRMA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crma: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, quiet while in reset
`define CRMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crma: next-cycle check failed");

`endif

// File: rtl/crma_pkg.sv
package crma_pkg;

  localparam int unsigned TICK_W = 32;
  localparam int unsigned CNT_W  = 64;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Command passed from the front end to the back end
  typedef struct packed {
    logic              is_init;
    logic [TICK_W-1:0] tick_delta;
    logic [CNT_W-1:0]  count_delta;
  } crma_cmd_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic idle;
    logic div_busy;
    logic in_out;
  } crma_back_stat_t;

endpackage

// File: rtl/counter_rate_moving_average.sv
// Moving-average rate meter. Each request carries a millisecond tick count
// and a cumulative byte counter; tuser high marks an init request, which
// clears the delta history, sets the baseline and gives no result. A sample
// request (tuser low) gives one result: the mean of the new counter delta
// and the last HISTORY_DEPTH deltas, times 1000, divided by the tick delta
// (0 when the tick delta is zero), all wrapping modulo 2^64. Requests are
// taken into a two-entry queue, so the input keeps accepting while a result
// waits, until the queue is full. A sample goes through the back end in
// order: take the command, form the mean (16 bits a cycle by reciprocal
// multiply), scale and start the divide, run the one-bit-per-cycle rate
// divide, take the quotient and load the output register, which waits while
// the previous result still waits on tready. A zero tick delta skips the
// divide. The back end takes the next command only once it is idle again.
module counter_rate_moving_average
  import crma_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // [31:0] sample_ticks, [95:32] counter_value
  input  logic        s_axis_tuser,  // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // [63:0] rate_per_second
);

`include "counter_rate_moving_average_defines.svh"

  logic              q_full;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;
  logic              in_accept;
  logic              cmd_pop;
  crma_cmd_t         front_cmd;
  crma_cmd_t         q_cmd;
  crma_back_stat_t   back_stat;

  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && !q_full;

  crma_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .func_i   (s_axis_tuser),
    .ticks_i  (s_axis_tdata[31:0]),
    .total_i  (s_axis_tdata[95:32]),
    .cmd_o    (front_cmd)
  );

  crma_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_cmd),
    .pop_i       (cmd_pop),
    .pop_data_o  (q_cmd),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  crma_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_ready_i (m_axis_tready),
    .stat_o      (back_stat)
  );

  // Queue never overfills
  `CRMA_ASSERT_IMPL(a_queue_bound, 1'b1, q_count <= QCNT_W'(QUEUE_DEPTH))
  // Divider only runs while the back end works on a sample
  `CRMA_ASSERT_IMPL(a_div_idle, back_stat.idle, !back_stat.div_busy)
  // A result only appears after the back end has finished a sample
  `CRMA_ASSERT_IMPL(a_out_source, $rose(m_axis_tvalid), $past(back_stat.in_out))
  // A request taken into an empty queue is visible to the back end next cycle
  `CRMA_ASSERT_NEXT(a_queue_fill, in_accept && q_empty && !cmd_pop, !q_empty)

endmodule

// File: rtl/crma_div.sv
// Restoring divider, one quotient bit per cycle
module crma_div
  import crma_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [CNT_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(CNT_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              fits;

  // Shift in the next dividend bit and try the subtract
  assign rem_sh  = {rem_q, quo_q[CNT_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(CNT_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_d  = {quo_q[CNT_W-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: rtl/crma_front.sv
// Front end: keeps the baselines and turns each request into a command
module crma_front
  import crma_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              func_i,
  input  logic [TICK_W-1:0] ticks_i,
  input  logic [CNT_W-1:0]  total_i,
  output crma_cmd_t         cmd_o
);

  logic [TICK_W-1:0] prev_ticks_q;
  logic [CNT_W-1:0]  prev_total_q;

  // Wrapping deltas against the last baseline
  always_comb begin
    cmd_o.is_init     = func_i;
    cmd_o.tick_delta  = ticks_i - prev_ticks_q;
    cmd_o.count_delta = total_i - prev_total_q;
  end

  // Both kinds of request move the baseline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ticks_q <= '0;
      prev_total_q <= '0;
    end else if (accept_i) begin
      prev_ticks_q <= ticks_i;
      prev_total_q <= total_i;
    end
  end

endmodule

// File: rtl/crma_fifo.sv
// Short command queue between front and back end
module crma_fifo
  import crma_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  crma_cmd_t         push_data_i,
  input  logic              pop_i,
  output crma_cmd_t         pop_data_o,
  output logic              full_o,
  output logic              empty_o,
  output logic [QCNT_W-1:0] count_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  crma_cmd_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  assign pop_data_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/crma_back.sv
// Back end: history, mean, scaling and rate divide, plus output register
module crma_back
  import crma_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  crma_cmd_t        cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  output logic [CNT_W-1:0] out_data_o,
  input  logic             out_ready_i,
  output crma_back_stat_t  stat_o
);

  // Number of low zero bits of a small constant
  function automatic int unsigned low_zeros(int unsigned v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 6; i++) begin
      if (v[n] == 1'b0) begin
        n = n + 1;
      end
    end
    return n;
  endfunction

  // Mean divisor split as 2^MEAN_SH * MEAN_ODD; the odd part is taken off
  // 16 bits a cycle by multiplying with a rounded-up reciprocal
  localparam int unsigned MEAN_D   = HISTORY_DEPTH + 1;
  localparam int unsigned MEAN_SH  = low_zeros(MEAN_D);
  localparam int unsigned MEAN_ODD = MEAN_D >> MEAN_SH;
  localparam int unsigned MAG_SH   = 26;
  localparam int unsigned MEAN_MAG = ((1 << MAG_SH) + MEAN_ODD - 1) / MEAN_ODD;
  localparam logic [26:0] MEAN_MAG_C = 27'(MEAN_MAG);
  localparam logic [4:0]  MEAN_ODD_C = 5'(MEAN_ODD);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MEAN  = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_RATE  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]        st_q, st_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [CNT_W-1:0]  res_q, res_d;
  logic [CNT_W-1:0]  hist_q [HISTORY_DEPTH];
  logic [CNT_W-1:0]  hsum_q;
  logic              out_valid_q;
  logic [CNT_W-1:0]  out_data_q;
  logic              out_load;

  logic [CNT_W-1:0]  msum;
  logic [CNT_W-1:0]  msrc_q, msrc_d;
  logic [4:0]        mrem_q, mrem_d;
  logic [CNT_W-1:0]  mean_q, mean_d;
  logic [1:0]        mdig_q, mdig_d;
  logic [20:0]       mv;
  logic [41:0]       mprod;
  logic [15:0]       mqd;
  logic [20:0]       mback;

  logic              div_start;
  logic [CNT_W-1:0]  div_dividend;
  logic [CNT_W-1:0]  div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [CNT_W-1:0]  div_quot;
  logic [CNT_W-1:0]  scaled;

  crma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sum of the new delta and the history, wrapping
  assign msum = hsum_q + cmd_i.count_delta;

  // One mean digit: remainder and next 16 dividend bits, quotient by reciprocal
  assign mv    = {mrem_q, msrc_q[CNT_W-1 -: 16]};
  assign mprod = 42'(mv) * 42'(MEAN_MAG_C);
  assign mqd   = mprod[MAG_SH +: 16];
  assign mback = 21'(mqd) * 21'(MEAN_ODD_C);

  // mean * 1000 as 1024 - 16 - 8, wrapping
  assign scaled = (mean_q << 10) - (mean_q << 4) - (mean_q << 3);

  assign div_dividend = scaled;
  assign div_divisor  = {{(CNT_W - TICK_W){1'b0}}, tick_q};

  assign cmd_pop_o = (st_q == ST_IDLE) && cmd_valid_i;

  // Sequencer
  always_comb begin
    st_d      = st_q;
    tick_d    = tick_q;
    res_d     = res_q;
    msrc_d    = msrc_q;
    mrem_d    = mrem_q;
    mean_d    = mean_q;
    mdig_d    = mdig_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i && !cmd_i.is_init) begin
          tick_d = cmd_i.tick_delta;
          msrc_d = msum >> MEAN_SH;
          mrem_d = '0;
          mdig_d = 2'd3;  // four 16-bit digits
          st_d   = ST_MEAN;
        end
      end
      ST_MEAN: begin
        msrc_d = msrc_q << 16;
        mrem_d = 5'(mv - mback);
        mean_d = {mean_q[CNT_W-17:0], mqd};
        mdig_d = mdig_q - 1'b1;
        if (mdig_q == '0) begin
          st_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (tick_q == '0) begin
          res_d = '0;
          st_d  = ST_OUT;
        end else begin
          div_start = 1'b1;
          st_d      = ST_RATE;
        end
      end
      ST_RATE: begin
        if (div_done) begin
          res_d = div_quot;
          st_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Control state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      mdig_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      mdig_q <= mdig_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Delta history and its running sum, updated as a command is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_q[k] <= '0;
      end
      hsum_q <= '0;
    end else if (cmd_pop_o) begin
      if (cmd_i.is_init) begin
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
          hist_q[k] <= '0;
        end
        hsum_q <= '0;
      end else begin
        for (int k = 1; k < HISTORY_DEPTH; k++) begin
          hist_q[k] <= hist_q[k-1];
        end
        hist_q[0] <= cmd_i.count_delta;
        hsum_q    <= hsum_q + cmd_i.count_delta - hist_q[HISTORY_DEPTH-1];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tick_q <= tick_d;
    res_q  <= res_d;
    msrc_q <= msrc_d;
    mrem_q <= mrem_d;
    mean_q <= mean_d;
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign stat_o.idle     = (st_q == ST_IDLE);
  assign stat_o.div_busy = div_busy;
  assign stat_o.in_out   = (st_q == ST_OUT);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned HIST_DEPTH  = 7;
  localparam int unsigned NUM_REQS    = 1100;
  localparam int unsigned DRAIN_CYC   = 300;
  localparam longint unsigned CYC_LIMIT = 3_000_000;
  localparam bit [63:0] RATE_SCALE    = 64'd1000;

  // Request kind carried on tuser
  typedef enum bit {
    REQ_SAMPLE = 1'b0,
    REQ_INIT   = 1'b1
  } req_kind_e;

  typedef struct {
    req_kind_e kind;
    bit [31:0] ticks;
    bit [63:0] total;
  } rate_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // [31:0] sample_ticks, [95:32] counter_value
  logic        s_axis_tuser = 1'b0; // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [63:0] rate_per_second

  rate_req_t   pending_reqs[$];
  bit [63:0]   expected_rates[$];
  int          error_count = 0;
  longint unsigned cycle_count = 0;
  int          req_gap;
  int          ready_stall;
  bit          calm_in;
  bit          calm_out;

  // Own copy of the meter state
  bit [31:0]   last_ticks;
  bit [63:0]   last_total;
  bit [63:0]   delta_hist[HIST_DEPTH];

  counter_rate_moving_average #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int gap_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_req(req_kind_e kind, bit [31:0] ticks, bit [63:0] total);
    rate_req_t req;
    req.kind  = kind;
    req.ticks = ticks;
    req.total = total;
    pending_reqs.push_back(req);
  endtask

  // Update the meter state for an accepted request and queue the expected rate
  task automatic predict_rate(req_kind_e kind, bit [31:0] ticks, bit [63:0] total);
    bit [31:0] tick_delta;
    bit [63:0] count_delta;
    bit [63:0] delta_sum;
    bit [63:0] mean;
    bit [63:0] scaled;
    if (kind == REQ_INIT) begin
      foreach (delta_hist[k]) delta_hist[k] = '0;
      last_ticks = ticks;
      last_total = total;
    end else begin
      tick_delta  = ticks - last_ticks;
      count_delta = total - last_total;
      last_ticks  = ticks;
      last_total  = total;
      delta_sum   = count_delta;
      foreach (delta_hist[k]) delta_sum = delta_sum + delta_hist[k];
      mean = delta_sum / 64'(HIST_DEPTH + 1);
      for (int k = HIST_DEPTH - 1; k > 0; k--) delta_hist[k] = delta_hist[k-1];
      delta_hist[0] = count_delta;
      scaled = mean * RATE_SCALE;
      if (tick_delta != '0) expected_rates.push_back(scaled / 64'(tick_delta));
      else expected_rates.push_back('0);
    end
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    rate_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      req_gap       <= 0;
      calm_in       <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_rate(req_kind_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[95:32]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_gap > 0) begin
          req_gap       <= req_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.kind;
          s_axis_tdata  <= {nxt.total, nxt.ticks};
          if ($urandom_range(0, 49) == 0) calm_in <= ~calm_in;
          req_gap <= gap_len(calm_in);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready stalls
  always @(posedge clk_i or negedge rst_ni) begin : mon_proc
    bit [63:0] exp_rate;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_stall   <= 0;
      calm_out      <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rates.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, m_axis_tdata);
          error_count++;
        end else begin
          exp_rate = expected_rates.pop_front();
          if (m_axis_tdata !== exp_rate) begin
            $display("%0t: rate_per_second mismatch, expected %0d, actual %0d",
                     $time, exp_rate, m_axis_tdata);
            error_count++;
          end
        end
      end
      if (ready_stall > 0) begin
        ready_stall   <= ready_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 49) == 0) calm_out <= ~calm_out;
        ready_stall <= gap_len(calm_out);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYC_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    bit [31:0] t;
    bit [63:0] c;
    int        r;
    int        run_len;

    foreach (delta_hist[k]) delta_hist[k] = '0;
    last_ticks = '0;
    last_total = '0;

    // Sample straight after reset, on zero baselines, then a zero tick delta
    push_req(REQ_SAMPLE, 32'd1000, 64'd5000);
    push_req(REQ_SAMPLE, 32'd1000, 64'd6000);
    // Init close to both wrap points, then wrapping deltas
    push_req(REQ_INIT, 32'hFFFF_FFF0, 64'hFFFF_FFFF_FFFF_FF00);
    push_req(REQ_SAMPLE, 32'h0000_0010, 64'h0000_0000_0000_0100);
    push_req(REQ_SAMPLE, 32'h0000_0011, 64'h0000_0000_0000_0100);
    // Huge deltas: the running sum wraps, then mean*1000 wraps
    t = 32'h0000_0011;
    c = 64'h100;
    for (int k = 0; k < 9; k++) begin
      t = t + 32'd7;
      c = c + 64'hF000_0000_0000_0000;
      push_req(REQ_SAMPLE, t, c);
    end
    // Largest tick delta
    push_req(REQ_SAMPLE, t - 32'd1, c + 64'h7FFF_FFFF_FFFF_FFFF);
    // Back-to-back inits, field extremes
    push_req(REQ_INIT, 32'h0, 64'h0);
    push_req(REQ_INIT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_req(REQ_SAMPLE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_req(REQ_SAMPLE, 32'h0, 64'h0);
    push_req(REQ_INIT, 32'h0, 64'h0);
    push_req(REQ_SAMPLE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);

    // Random part: mostly init followed by a run of ordinary samples
    while (pending_reqs.size() < NUM_REQS) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        t = $urandom();
        c = rand64();
        push_req(REQ_INIT, t, c);
        run_len = $urandom_range(1, 20);
        for (int k = 0; k < run_len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 5) t = t;
          else if (r < 80) t = t + $urandom_range(1, 2000);
          else if (r < 95) t = t + $urandom_range(2000, 100000);
          else t = t + $urandom();
          r = $urandom_range(0, 99);
          if (r < 30) c = c + $urandom_range(0, 100000);
          else if (r < 70) c = c + $urandom();
          else if (r < 90) c = c + (rand64() >> $urandom_range(0, 63));
          else c = c + rand64();
          push_req(REQ_SAMPLE, t, c);
        end
      end else if (r < 95) begin
        push_req(REQ_SAMPLE, $urandom(), rand64());
      end else begin
        push_req(REQ_INIT, $urandom(), rand64());
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_rates.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/crma_pkg.sv
rtl/crma_div.sv
rtl/crma_front.sv
rtl/crma_fifo.sv
rtl/crma_back.sv
rtl/counter_rate_moving_average.sv
tb/testbench.sv
